### sv/oqd_pkg.sv
// ----------------------------------------------------------------------------
// oqd_pkg
// Shared constants and types of the ordered queue with delete by key.
// ----------------------------------------------------------------------------
package oqd_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned ID_W  = 32;
  // Counts span 0..DEPTH, indexes span 0..DEPTH-1.
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef logic signed [ID_W-1:0] id_t;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_DUMP   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  // Controls broadcast to every cell of the chain.
  typedef struct packed {
    logic shift;
    logic clear;
    logic cmp;
  } cell_ctrl_t;

endpackage

### sv/oqd_cell.sv
// ----------------------------------------------------------------------------
// oqd_cell
// One queue slot: id, live bit and registered key match. Takes the
// neighbor's contents when the chain rotates.
// ----------------------------------------------------------------------------
module oqd_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  oqd_pkg::cell_ctrl_t ctrl_i,
  input  logic               wr_i,
  input  logic               kill_i,
  input  oqd_pkg::id_t       key_i,
  input  oqd_pkg::id_t       nb_id_i,
  input  logic               nb_live_i,
  output oqd_pkg::id_t       id_o,
  output logic               live_o,
  output logic               match_o
);

  oqd_pkg::id_t id_q, id_d;
  logic         live_q, live_d;
  logic         match_q, match_d;

  always_comb begin
    id_d    = id_q;
    live_d  = live_q;
    match_d = match_q;
    priority if (ctrl_i.clear) begin
      live_d = 1'b0;
    end else if (ctrl_i.shift) begin
      id_d   = nb_id_i;
      live_d = nb_live_i;
    end else if (wr_i) begin
      id_d   = key_i;
      live_d = 1'b1;
    end else if (kill_i) begin
      live_d = 1'b0;
    end
    if (ctrl_i.cmp) begin
      match_d = live_q && (id_q == key_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q  <= 1'b0;
      match_q <= 1'b0;
    end else begin
      live_q  <= live_d;
      match_q <= match_d;
    end
  end

  // Ids carry no reset: a slot is read only once written.
  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

  assign id_o    = id_q;
  assign live_o  = live_q;
  assign match_o = match_q;

endmodule

### sv/ordered_queue_delete_by_key.sv
// ----------------------------------------------------------------------------
// ordered_queue_delete_by_key
// Ordered id queue built as a ring of slot cells, with removal by value.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry cmd_i and item_id_i; output beats carry out_id_o,
//   last_o, empty_res_o and overflowed_o. A beat moves when valid is high
//   and stall is low.
//   Append and clear complete without leaving idle. Remove first has
//   every cell compare its id with the key, then, in the kill state,
//   drops the earliest match through a lowest-set-bit pick over the
//   match vector. Dump rotates the ring once around its DEPTH (64) slots,
//   waiting on a stalled receiver, one result per live slot at the head.
//   A dump of an empty queue gives one beat flagged empty.
//   While remove or dump is in progress in_stall_o is high. The output
//   register lets the next item in while a result still waits; a stalled
//   receiver holds the ring at a live head slot.
//   Reset clears all live bits, the fill count and the overflow flag;
//   no output beat is pending after reset.
// ----------------------------------------------------------------------------
module ordered_queue_delete_by_key (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         cmd_i,
  input  logic signed [31:0] item_id_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] out_id_o,
  output logic               last_o,
  output logic               empty_res_o,
  output logic               overflowed_o
);

  localparam int unsigned Depth = oqd_pkg::DEPTH;
  localparam int unsigned CntW  = oqd_pkg::CNT_W;
  localparam int unsigned IdxW  = oqd_pkg::IDX_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KILL,
    ST_DUMP,
    ST_EMPTY
  } state_e;

  typedef oqd_pkg::cmd_e cmd_e_t;

  state_e              state_q;
  logic [CntW-1:0]     used_q;
  logic [CntW-1:0]     cnt_q;
  logic [CntW-1:0]     remain_q;
  logic [IdxW-1:0]     step_q;
  logic                ovf_q;
  logic                out_valid_q;
  oqd_pkg::id_t        out_id_q;
  logic                out_last_q;
  logic                out_empty_q;
  logic                out_ovf_q;

  oqd_pkg::id_t        cell_id   [Depth];
  logic [Depth-1:0]    cell_live;
  logic [Depth-1:0]    match_vec;
  logic [Depth-1:0]    wr_vec;
  logic [Depth-1:0]    kill_vec;
  oqd_pkg::cell_ctrl_t ctrl;

  logic   accept;
  cmd_e_t cmd;
  logic   out_free;
  logic   adv;
  logic   has_room;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign cmd        = oqd_pkg::cmd_e'(cmd_i);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign has_room   = (used_q < CntW'(Depth));
  // Advance the ring unless a live head must wait for the output register.
  assign adv        = (state_q == ST_DUMP) && (!cell_live[0] || out_free);

  always_comb begin
    ctrl.shift = adv;
    ctrl.clear = accept && (cmd == oqd_pkg::CMD_CLEAR);
    ctrl.cmp   = accept && (cmd == oqd_pkg::CMD_REMOVE);
  end

  // Earliest match only: isolate the lowest set bit.
  assign kill_vec = (state_q == ST_KILL) ? (match_vec & (~match_vec + Depth'(1)))
                                         : '0;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    assign wr_vec[i] = accept && (cmd == oqd_pkg::CMD_APPEND) && has_room
                       && (used_q == CntW'(i));

    oqd_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .wr_i      (wr_vec[i]),
      .kill_i    (kill_vec[i]),
      .key_i     (item_id_i),
      .nb_id_i   (cell_id[(i + 1) % Depth]),
      .nb_live_i (cell_live[(i + 1) % Depth]),
      .id_o      (cell_id[i]),
      .live_o    (cell_live[i]),
      .match_o   (match_vec[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      cnt_q       <= '0;
      remain_q    <= '0;
      step_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_id_q    <= '0;
      out_last_q  <= 1'b0;
      out_empty_q <= 1'b0;
      out_ovf_q   <= 1'b0;
    end else begin
      // Drop the held beat once taken; a new load below overrides.
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (cmd)
              oqd_pkg::CMD_APPEND: begin
                if (has_room) begin
                  used_q <= used_q + CntW'(1);
                  cnt_q  <= cnt_q + CntW'(1);
                end else begin
                  ovf_q <= 1'b1;
                end
              end
              oqd_pkg::CMD_REMOVE: begin
                state_q <= ST_KILL;
              end
              oqd_pkg::CMD_DUMP: begin
                remain_q <= cnt_q;
                step_q   <= '0;
                state_q  <= (cnt_q == '0) ? ST_EMPTY : ST_DUMP;
              end
              oqd_pkg::CMD_CLEAR: begin
                used_q <= '0;
                cnt_q  <= '0;
                ovf_q  <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ST_KILL: begin
          if (|match_vec) begin
            cnt_q <= cnt_q - CntW'(1);
          end
          state_q <= ST_IDLE;
        end
        ST_DUMP: begin
          if (adv) begin
            if (cell_live[0]) begin
              out_valid_q <= 1'b1;
              out_id_q    <= cell_id[0];
              out_last_q  <= (remain_q == CntW'(1));
              out_empty_q <= 1'b0;
              out_ovf_q   <= ovf_q;
              remain_q    <= remain_q - CntW'(1);
            end
            step_q <= step_q + IdxW'(1);
            if (step_q == IdxW'(Depth - 1)) begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_EMPTY: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_id_q    <= '0;
            out_last_q  <= 1'b1;
            out_empty_q <= 1'b1;
            out_ovf_q   <= ovf_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_id_o     = out_id_q;
  assign last_o       = out_last_q;
  assign empty_res_o  = out_empty_q;
  assign overflowed_o = out_ovf_q;

endmodule
